// ===== sv/rrtes_pkg.sv =====
// ----------------------------------------------------------------------------
// rrtes_pkg: shared types and codes for the round-robin timed event scheduler
// Action and job-type codes, request/result words, controller interface.
// ----------------------------------------------------------------------------
package rrtes_pkg;

	localparam int DEF_ENTRIES = 16;

	localparam logic [3:0] ACT_LOAD    = 4'd0;
	localparam logic [3:0] ACT_POLL    = 4'd1;
	localparam logic [3:0] ACT_FORCE   = 4'd2;
	localparam logic [3:0] ACT_DONE    = 4'd3;
	localparam logic [3:0] ACT_RESET   = 4'd4;
	localparam logic [3:0] ACT_ZAP     = 4'd5;
	localparam logic [3:0] ACT_NEXT    = 4'd6;
	localparam logic [3:0] ACT_ALLDONE = 4'd7;
	localparam logic [3:0] ACT_NETDONE = 4'd8;

	localparam logic [2:0] KIND_SHUTDOWN = 3'd4;  // highest type that stamps both times
	localparam logic [2:0] KIND_NET      = 3'd5;

	localparam logic [4:0] HOURS_PER_DAY = 5'd24;
	localparam logic [2:0] DAYS_PER_WEEK = 3'd7;

	typedef struct packed {
		logic [3:0]  action;
		logic [3:0]  index;
		logic [31:0] now_seconds;
		logic [4:0]  hour_now;
		logic [2:0]  weekday_now;
		logic        user_busy;
		logic [2:0]  job_kind;
		logic [23:0] hour_bits;
		logic [6:0]  day_bits;
		logic [15:0] redo_minutes;
		logic [15:0] retry_minutes;
		logic [7:0]  node_id;
	} req_word_t;

	typedef struct packed {
		logic       job_found;
		logic [3:0] job_slot;
		logic [2:0] job_type;
		logic       net_blocked;
	} rsp_word_t;

	// controller -> datapath
	typedef struct packed {
		logic cap;         // latch request, set start address
		logic load;        // write slot config, clear stamps, mark valid
		logic stamp_now;   // both stamps <= now
		logic stamp_zero;  // both stamps <= 0
		logic zap;         // clear valid
		logic ptr_idx;     // pointer <= addressed slot
		logic ptr_step;    // pointer <= slot after addressed one
		logic adv;         // next slot of scan or sweep
		logic run;         // run addressed job, fill result
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [3:0] action;
		logic       in_table;
		logic       load_ok;
		logic       cnt_zero;
		logic       slot_valid;
		logic       due;
		logic       net_match;
		logic       scan_last;
		logic       sweep_last;
	} ctl_sts_t;

endpackage

// ===== sv/rrtes_dp.sv =====
// ----------------------------------------------------------------------------
// rrtes_dp: scheduler datapath
// Job table memories, valid bits, pointer, scan counter, due check, result.
// ----------------------------------------------------------------------------
module rrtes_dp #(
	parameter int ENTRIES = rrtes_pkg::DEF_ENTRIES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrtes_pkg::req_word_t cmd,
	input  logic                 cfg_valid,
	input  logic [4:0]           cfg_data,
	input  rrtes_pkg::ctl_cmd_t  ctl,
	output rrtes_pkg::ctl_sts_t  sts,
	output rrtes_pkg::rsp_word_t result
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int EW = (CW > 5) ? CW : 5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] hours;
		logic [6:0]  days;
		logic [15:0] redo;
		logic [15:0] retry;
		logic [7:0]  node;
	} slot_t;

	slot_t                cfg_mem  [ENTRIES];
	logic [31:0]          succ_mem [ENTRIES];
	logic [31:0]          try_mem  [ENTRIES];
	slot_t                rd_cfg_q;
	logic [31:0]          rd_succ_q;
	logic [31:0]          rd_try_q;

	rrtes_pkg::req_word_t item_q;
	rrtes_pkg::rsp_word_t result_q;
	logic [ENTRIES-1:0]   valid_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        ptr_q;
	logic [CW-1:0]        scan_q;
	logic [4:0]           count_q;

	logic [EW-1:0] ent_e, cnt, addr_e, nxt_e, ptr_e, idx_live_e, idx_e, scan_e;
	logic [AW-1:0] start_addr;
	logic          is_poll, valid_at;
	logic          hr_ok, day_ok, early_s, early_t;
	logic [32:0]   diff_s, diff_t;
	logic [21:0]   gap_s, gap_t;
	logic          wr_succ, wr_try, run_both, run_try;
	logic [31:0]   stamp_d;

	assign ent_e      = EW'(ENTRIES);
	assign cnt        = (EW'(count_q) > ent_e) ? ent_e : EW'(count_q);
	assign addr_e     = EW'(addr_q);
	assign ptr_e      = EW'(ptr_q);
	assign scan_e     = EW'(scan_q);
	assign idx_live_e = EW'(cmd.index);
	assign idx_e      = EW'(item_q.index);
	assign is_poll    = (item_q.action == rrtes_pkg::ACT_POLL);
	assign valid_at   = valid_q[addr_q];

	// poll wraps at the loaded count; net done scans and sweeps just count up
	always_comb begin
		if (is_poll && (addr_e + EW'(1) >= cnt)) nxt_e = '0;
		else nxt_e = addr_e + EW'(1);
	end

	always_comb begin
		case (cmd.action)
			rrtes_pkg::ACT_POLL:    start_addr = (ptr_e < cnt) ? ptr_q : '0;
			rrtes_pkg::ACT_ALLDONE,
			rrtes_pkg::ACT_NETDONE: start_addr = '0;
			default:                start_addr = idx_live_e[AW-1:0];
		endcase
	end

	// minutes elapsed < interval  <=>  seconds elapsed < 60 * interval
	assign gap_s  = ({6'b0, rd_cfg_q.redo} << 6) - ({6'b0, rd_cfg_q.redo} << 2);
	assign gap_t  = ({6'b0, rd_cfg_q.retry} << 6) - ({6'b0, rd_cfg_q.retry} << 2);
	assign diff_s = {1'b0, item_q.now_seconds} - {1'b0, rd_succ_q};
	assign diff_t = {1'b0, item_q.now_seconds} - {1'b0, rd_try_q};
	assign early_s = diff_s[32] ? (rd_cfg_q.redo != '0)
		: (diff_s[31:0] < {10'b0, gap_s});
	assign early_t = diff_t[32] ? (rd_cfg_q.retry != '0)
		: (diff_t[31:0] < {10'b0, gap_t});
	assign hr_ok  = (item_q.hour_now < rrtes_pkg::HOURS_PER_DAY)
		&& rd_cfg_q.hours[item_q.hour_now];
	assign day_ok = (item_q.weekday_now < rrtes_pkg::DAYS_PER_WEEK)
		&& rd_cfg_q.days[item_q.weekday_now];

	always_comb begin
		sts.action     = item_q.action;
		sts.in_table   = idx_e < cnt;
		sts.load_ok    = idx_e < ent_e;
		sts.cnt_zero   = (cnt == '0);
		sts.slot_valid = valid_at;
		sts.due        = valid_at && hr_ok && day_ok && !early_s && !early_t;
		sts.net_match  = valid_at && (rd_cfg_q.kind == rrtes_pkg::KIND_NET)
			&& (rd_cfg_q.node == item_q.node_id);
		sts.scan_last  = (scan_e + EW'(1) == cnt);
		sts.sweep_last = (addr_e == ent_e - EW'(1));
	end

	assign run_both = ctl.run && (rd_cfg_q.kind <= rrtes_pkg::KIND_SHUTDOWN);
	assign run_try  = ctl.run && (rd_cfg_q.kind == rrtes_pkg::KIND_NET) && !item_q.user_busy;
	assign wr_succ  = ctl.load || ctl.stamp_now || ctl.stamp_zero || run_both;
	assign wr_try   = wr_succ || run_try;
	assign stamp_d  = (ctl.load || ctl.stamp_zero) ? 32'd0 : item_q.now_seconds;

	always_ff @(posedge clk) begin
		rd_cfg_q  <= cfg_mem[addr_q];
		rd_succ_q <= succ_mem[addr_q];
		rd_try_q  <= try_mem[addr_q];
		if (ctl.load) begin
			cfg_mem[addr_q] <= '{kind: item_q.job_kind, hours: item_q.hour_bits,
				days: item_q.day_bits, redo: item_q.redo_minutes,
				retry: item_q.retry_minutes, node: item_q.node_id};
		end
		if (wr_succ) succ_mem[addr_q] <= stamp_d;
		if (wr_try)  try_mem[addr_q]  <= stamp_d;
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) item_q <= cmd;
		if (ctl.cap) begin
			result_q <= '0;
		end else if (ctl.run) begin
			result_q.job_found   <= 1'b1;
			result_q.job_slot    <= addr_e[3:0];
			result_q.job_type    <= rd_cfg_q.kind;
			result_q.net_blocked <= (rd_cfg_q.kind == rrtes_pkg::KIND_NET) && item_q.user_busy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			addr_q  <= '0;
			ptr_q   <= '0;
			scan_q  <= '0;
			count_q <= '0;
		end else begin
			if (cfg_valid) count_q <= cfg_data;
			if (ctl.cap) begin
				addr_q <= start_addr;
				scan_q <= '0;
			end else if (ctl.adv) begin
				addr_q <= nxt_e[AW-1:0];
				scan_q <= scan_q + CW'(1);
			end
			if (ctl.load) valid_q[addr_q] <= 1'b1;
			if (ctl.zap)  valid_q[addr_q] <= 1'b0;
			if (ctl.ptr_idx)  ptr_q <= addr_q;
			if (ctl.ptr_step) ptr_q <= nxt_e[AW-1:0];
		end
	end

	assign result = result_q;

endmodule

// ===== sv/rrtes_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrtes_ctrl: scheduler controller
// Sequences dispatch, slot reads, scan and sweep steps, and the reply strobe.
// ----------------------------------------------------------------------------
module rrtes_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rrtes_pkg::ctl_sts_t sts,
	output rrtes_pkg::ctl_cmd_t ctl,
	output logic                busy,
	output logic                done
);

	typedef enum logic [2:0] {
		S_IDLE, S_DISP, S_WAIT, S_EVAL, S_SWEEP, S_REPLY
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.cap = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_REPLY;
				unique case (sts.action)
					rrtes_pkg::ACT_LOAD:    ctl.load       = sts.load_ok;
					rrtes_pkg::ACT_DONE:    ctl.stamp_now  = sts.in_table;
					rrtes_pkg::ACT_RESET:   ctl.stamp_zero = sts.in_table;
					rrtes_pkg::ACT_ZAP:     ctl.zap        = sts.in_table;
					rrtes_pkg::ACT_NEXT:    ctl.ptr_idx    = sts.in_table;
					rrtes_pkg::ACT_FORCE:   if (sts.in_table) state_d = S_WAIT;
					rrtes_pkg::ACT_POLL,
					rrtes_pkg::ACT_NETDONE: if (!sts.cnt_zero) state_d = S_WAIT;
					rrtes_pkg::ACT_ALLDONE: state_d = S_SWEEP;
					default:                state_d = S_REPLY;
				endcase
			end
			S_WAIT: state_d = S_EVAL;
			S_EVAL: begin
				state_d = S_REPLY;
				unique case (sts.action)
					rrtes_pkg::ACT_POLL: begin
						ctl.ptr_step = 1'b1;
						if (sts.due) ctl.run = 1'b1;
						else if (!sts.scan_last) begin
							ctl.adv = 1'b1;
							state_d = S_WAIT;
						end
					end
					rrtes_pkg::ACT_FORCE: ctl.run = sts.slot_valid;
					rrtes_pkg::ACT_NETDONE: begin
						ctl.stamp_now = sts.net_match;
						if (!sts.scan_last) begin
							ctl.adv = 1'b1;
							state_d = S_WAIT;
						end
					end
					default: state_d = S_REPLY;
				endcase
			end
			S_SWEEP: begin
				ctl.stamp_now = 1'b1;
				if (!sts.sweep_last) ctl.adv = 1'b1;
				else state_d = S_REPLY;
			end
			S_REPLY: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != S_IDLE);
			done    <= (state_d == S_REPLY);
		end
	end

endmodule

// ===== sv/round_robin_timed_event_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_timed_event_scheduler: table of timed jobs, round-robin poll
// Table edits go from dispatch straight to the reply; a poll or net done reads
//   and checks each scanned slot in turn, and all done stamps every entry.
// Throughput: one word at a time; busy stays high until the strobe cycle ends.
//   Each scanned slot takes a memory read, then a due check.
// Reset: asynchronous, all jobs invalid, pointer and entry_count zero.
//   Result words are never stalled by the receiver.
// ----------------------------------------------------------------------------
module round_robin_timed_event_scheduler #(
	parameter int ENTRIES = rrtes_pkg::DEF_ENTRIES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request word
	input  logic                 start,
	output logic                 busy,
	input  rrtes_pkg::req_word_t cmd,
	// result word, one-cycle strobe
	output logic                 result_valid,
	output rrtes_pkg::rsp_word_t result,
	// entry_count write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [4:0]           cfg_data
);

	rrtes_pkg::ctl_cmd_t ctl;
	rrtes_pkg::ctl_sts_t sts;

	// entry_count may be written any time the block is idle
	assign cfg_ready = 1'b1;

	// controller: dispatch, scan/sweep sequencing, reply strobe
	rrtes_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (result_valid)
	);

	// datapath: job table, pointer, due checks, result register
	rrtes_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.result    (result)
	);

`ifndef ASSERT_OFF
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("strobe outside busy window");
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not raise busy");
	a_blocked_found: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.net_blocked) |-> result.job_found)
		else $error("net_blocked without a job");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.job_found) |-> (result.job_slot == 4'd0))
		else $error("slot set without a job");
`endif

endmodule
